[rtl/core/tgc_pkg.sv]
package tgc_pkg;

   localparam int VAL_BITS      = 13;
   localparam int GESTURE_BITS  = 2;
   localparam int COUNT_BITS    = 4;
   localparam int TIME_BITS     = 32;
   localparam int CSR_DATA_BITS = 16;
   localparam int CSR_IDX_BITS  = 1;

   localparam logic [CSR_DATA_BITS-1:0] HOLD_MS_RESET = 16'd250;
   localparam logic [CSR_DATA_BITS-1:0] TAP_MS_RESET  = 16'd500;

   localparam logic [CSR_IDX_BITS-1:0] CSR_HOLD_MS = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TAP_MS  = 1'd1;

   typedef enum logic [GESTURE_BITS-1:0] {
      GEST_NONE  = 2'd0,
      GEST_PRESS = 2'd1,
      GEST_DRAG  = 2'd2,
      GEST_PINCH = 2'd3
   } gesture_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SQRT,
      ST_OUT
   } state_type;

endpackage

[rtl/core/tgc_if.sv]
interface tgc_req_if #(
   parameter int COORD_BITS = 12
);
   logic                                 valid;
   logic                                 ready;
   logic [tgc_pkg::COUNT_BITS-1:0]       touch_count;
   logic [COORD_BITS-1:0]                x0;
   logic [COORD_BITS-1:0]                y0;
   logic [COORD_BITS-1:0]                x1;
   logic [COORD_BITS-1:0]                y1;
   logic [tgc_pkg::TIME_BITS-1:0]        now_ms;

   modport source (output valid, touch_count, x0, y0, x1, y1, now_ms, input ready);
   modport sink (input valid, touch_count, x0, y0, x1, y1, now_ms, output ready);
endinterface

interface tgc_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [tgc_pkg::GESTURE_BITS-1:0]     gesture;
   logic signed [tgc_pkg::VAL_BITS-1:0]  value_one;
   logic signed [tgc_pkg::VAL_BITS-1:0]  value_two;

   modport source (output valid, gesture, value_one, value_two, input ready);
   modport sink (input valid, gesture, value_one, value_two, output ready);
endinterface

[rtl/core/tgc_isqrt.sv]
module tgc_isqrt #(
   parameter int OP_BITS = 13
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [OP_BITS-1:0]         operand,
   output logic                       done,
   output logic [(OP_BITS+1)/2-1:0]   root
);
   localparam int STEPS    = (OP_BITS + 1) / 2;
   localparam int PAD      = 2 * STEPS;
   localparam int REM_BITS = STEPS + 3;
   localparam int CNT_BITS = $clog2(STEPS + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [PAD-1:0]      op_ff, op_in;
   logic [REM_BITS-1:0] rem_ff, rem_in;
   logic [STEPS-1:0]    root_ff, root_in;

   logic [REM_BITS-1:0] rem_shift;
   logic [REM_BITS-1:0] trial;
   logic                fits;

   // one result bit per step: bring down two operand bits, try root*4+1
   always_comb begin
      rem_shift = {rem_ff[REM_BITS-3:0], op_ff[PAD-1 -: 2]};
      trial     = {1'b0, root_ff, 2'b01};
      fits      = rem_shift >= trial;

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      op_in   = op_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(STEPS);
         op_in   = PAD'(operand);
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         op_in   = {op_ff[PAD-3:0], 2'b00};
         rem_in  = fits ? rem_shift - trial : rem_shift;
         root_in = {root_ff[STEPS-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      op_ff   <= op_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

[rtl/core/touch_gesture_classifier.sv]
// touch gesture classifier
// req_ch carries one touch-panel frame per transfer (touch count, two points,
// millisecond timestamp); rsp_ch returns exactly one result per frame:
// gesture code and two signed 13-bit values.
// csr_wr_en/csr_index/csr_wdata write hold_ms (index 0) and tap_ms (index 1)
// at any clock edge; write them only while no frame is in flight.
// one frame at a time: req_ch.ready is high only while the block is empty.
// a press, drag or idle frame gives its result in the cycle after the transfer;
// a pinch frame runs the bit-serial square root, one root bit per cycle,
// and its result is registered when the root is done.
// the result sits in an output register until rsp_ch.ready; while the
// receiver stalls, no new frame is taken.
// reset (synchronous, active high) restores hold_ms 250, tap_ms 500 and an
// idle gesture state with no touch held.
module touch_gesture_classifier #(
   parameter int COORD_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   tgc_req_if.sink                             req_ch,
   tgc_rsp_if.source                           rsp_ch,
   input  logic                                csr_wr_en,
   input  logic [tgc_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [tgc_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import tgc_pkg::*;

   localparam int SUM_BITS  = COORD_BITS + 1;
   localparam int ROOT_BITS = (SUM_BITS + 1) / 2;

   state_type                    state_ff, state_in;
   logic [CSR_DATA_BITS-1:0]     hold_ms_ff, hold_ms_in;
   logic [CSR_DATA_BITS-1:0]     tap_ms_ff, tap_ms_in;
   logic                         active_ff, active_in;
   logic [TIME_BITS-1:0]         press_start_ff, press_start_in;
   logic                         first_drag_ff, first_drag_in;
   logic                         first_pinch_ff, first_pinch_in;
   logic [COORD_BITS-1:0]        last_x_ff, last_x_in;
   logic [COORD_BITS-1:0]        last_y_ff, last_y_in;
   logic [ROOT_BITS-1:0]         last_mag_ff, last_mag_in;
   gesture_type                  gesture_ff, gesture_in;
   logic [VAL_BITS-1:0]          value_one_ff, value_one_in;
   logic [VAL_BITS-1:0]          value_two_ff, value_two_in;

   logic [TIME_BITS-1:0]         elapsed;
   logic [COORD_BITS-1:0]        dx_abs, dy_abs;
   logic [SUM_BITS-1:0]          l1_sum;
   logic                         sqrt_start;
   logic                         sqrt_done;
   logic [ROOT_BITS-1:0]         sqrt_root;

   tgc_isqrt #(
      .OP_BITS (SUM_BITS)
   ) u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sqrt_start),
      .operand (l1_sum),
      .done    (sqrt_done),
      .root    (sqrt_root)
   );

   always_comb begin
      dx_abs = (req_ch.x0 >= req_ch.x1) ? req_ch.x0 - req_ch.x1 : req_ch.x1 - req_ch.x0;
      dy_abs = (req_ch.y0 >= req_ch.y1) ? req_ch.y0 - req_ch.y1 : req_ch.y1 - req_ch.y0;
      l1_sum = SUM_BITS'(dx_abs) + SUM_BITS'(dy_abs);
      // a new hold starts at this frame, so its elapsed time is zero
      elapsed = active_ff ? req_ch.now_ms - press_start_ff : '0;
   end

   always_comb begin
      hold_ms_in = hold_ms_ff;
      tap_ms_in  = tap_ms_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_HOLD_MS: hold_ms_in = csr_wdata;
            CSR_TAP_MS:  tap_ms_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in       = state_ff;
      active_in      = active_ff;
      press_start_in = press_start_ff;
      first_drag_in  = first_drag_ff;
      first_pinch_in = first_pinch_ff;
      last_x_in      = last_x_ff;
      last_y_in      = last_y_ff;
      last_mag_in    = last_mag_ff;
      gesture_in     = gesture_ff;
      value_one_in   = value_one_ff;
      value_two_in   = value_two_ff;
      sqrt_start     = 1'b0;
      req_ch.ready   = (state_ff == ST_IDLE);
      rsp_ch.valid   = (state_ff == ST_OUT);

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               gesture_in   = GEST_NONE;
               value_one_in = '0;
               value_two_in = '0;
               state_in     = ST_OUT;
               if (req_ch.touch_count != '0) begin
                  active_in = 1'b1;
                  if (!active_ff) begin
                     press_start_in = req_ch.now_ms;
                  end
                  last_x_in = req_ch.x0;
                  last_y_in = req_ch.y0;
                  if (elapsed >= TIME_BITS'(hold_ms_ff)) begin
                     if (req_ch.touch_count > COUNT_BITS'(1)) begin
                        gesture_in = GEST_PINCH;
                        sqrt_start = 1'b1;
                        state_in   = ST_SQRT;
                     end else begin
                        gesture_in = GEST_DRAG;
                        if (first_drag_ff) begin
                           first_drag_in  = 1'b0;
                           first_pinch_in = 1'b1;
                        end else begin
                           value_one_in = VAL_BITS'(req_ch.x0) - VAL_BITS'(last_x_ff);
                           value_two_in = VAL_BITS'(req_ch.y0) - VAL_BITS'(last_y_ff);
                        end
                     end
                  end
               end else if (active_ff) begin
                  if (elapsed < TIME_BITS'(tap_ms_ff)) begin
                     gesture_in   = GEST_PRESS;
                     value_one_in = VAL_BITS'(last_x_ff);
                     value_two_in = VAL_BITS'(last_y_ff);
                  end
                  // release ends the hold whether or not it was a press
                  active_in      = 1'b0;
                  press_start_in = '0;
                  first_drag_in  = 1'b1;
                  first_pinch_in = 1'b1;
                  last_x_in      = '0;
                  last_y_in      = '0;
                  last_mag_in    = '0;
               end
            end
         end
         ST_SQRT: begin
            if (sqrt_done) begin
               last_mag_in = sqrt_root;
               if (first_pinch_ff) begin
                  first_pinch_in = 1'b0;
                  first_drag_in  = 1'b1;
               end else begin
                  value_one_in = VAL_BITS'(sqrt_root) - VAL_BITS'(last_mag_ff);
               end
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         hold_ms_ff     <= HOLD_MS_RESET;
         tap_ms_ff      <= TAP_MS_RESET;
         active_ff      <= 1'b0;
         press_start_ff <= '0;
         first_drag_ff  <= 1'b1;
         first_pinch_ff <= 1'b1;
         last_x_ff      <= '0;
         last_y_ff      <= '0;
         last_mag_ff    <= '0;
      end else begin
         state_ff       <= state_in;
         hold_ms_ff     <= hold_ms_in;
         tap_ms_ff      <= tap_ms_in;
         active_ff      <= active_in;
         press_start_ff <= press_start_in;
         first_drag_ff  <= first_drag_in;
         first_pinch_ff <= first_pinch_in;
         last_x_ff      <= last_x_in;
         last_y_ff      <= last_y_in;
         last_mag_ff    <= last_mag_in;
      end
      gesture_ff   <= gesture_in;
      value_one_ff <= value_one_in;
      value_two_ff <= value_two_in;
   end

   assign rsp_ch.gesture   = gesture_ff;
   assign rsp_ch.value_one = value_one_ff;
   assign rsp_ch.value_two = value_two_ff;

endmodule

[tb/sv/tgc_gesture_checker.sv]
`timescale 1ns / 100ps

module tgc_gesture_checker #(
   parameter int COORD_BITS = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   tgc_req_if                                req_ch,
   tgc_rsp_if                                rsp_ch,
   input  logic                              csr_wr_en,
   input  logic [tgc_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [tgc_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output int                                mismatches,
   output int                                awaited
);
   import tgc_pkg::*;

   localparam int SPAN_BITS = COORD_BITS + 1;
   localparam int MAG_BITS  = 7;

   typedef struct packed {
      gesture_type                gesture;
      logic signed [VAL_BITS-1:0] value_one;
      logic signed [VAL_BITS-1:0] value_two;
   } gesture_result;

   logic [CSR_DATA_BITS-1:0] hold_ms;
   logic [CSR_DATA_BITS-1:0] tap_ms;
   logic                     touch_held;
   logic [TIME_BITS-1:0]     hold_start;
   logic                     drag_fresh;
   logic                     pinch_fresh;
   logic [COORD_BITS-1:0]    prev_x;
   logic [COORD_BITS-1:0]    prev_y;
   logic [MAG_BITS-1:0]      prev_mag;
   gesture_result            expected_gestures[$];

   initial begin
      mismatches = 0;
      awaited    = 0;
   end

   function automatic logic [SPAN_BITS-1:0] coord_gap(input logic [COORD_BITS-1:0] a,
                                                      input logic [COORD_BITS-1:0] b);
      return (a >= b) ? SPAN_BITS'(a - b) : SPAN_BITS'(b - a);
   endfunction

   function automatic logic [MAG_BITS-1:0] root_floor(input logic [SPAN_BITS-1:0] v);
      logic [MAG_BITS-1:0] root;
      root = '0;
      for (int b = MAG_BITS - 1; b >= 0; b--) begin
         root[b] = 1'b1;
         if (int'(root) * int'(root) > int'(v)) begin
            root[b] = 1'b0;
         end
      end
      return root;
   endfunction

   function automatic void release_touch();
      touch_held  = 1'b0;
      hold_start  = '0;
      drag_fresh  = 1'b1;
      pinch_fresh = 1'b1;
      prev_x      = '0;
      prev_y      = '0;
      prev_mag    = '0;
   endfunction

   function automatic gesture_result classify_frame(input logic [COUNT_BITS-1:0] count,
                                                    input logic [COORD_BITS-1:0] fx0,
                                                    input logic [COORD_BITS-1:0] fy0,
                                                    input logic [COORD_BITS-1:0] fx1,
                                                    input logic [COORD_BITS-1:0] fy1,
                                                    input logic [TIME_BITS-1:0]  now);
      gesture_result       r;
      logic [TIME_BITS-1:0] held_for;
      logic [MAG_BITS-1:0]  mag;
      r.gesture   = GEST_NONE;
      r.value_one = '0;
      r.value_two = '0;
      if (count != '0) begin
         if (!touch_held) begin
            touch_held = 1'b1;
            hold_start = now;
         end
         held_for = now - hold_start;
         if (held_for >= TIME_BITS'(hold_ms)) begin
            if (count > 1) begin
               mag = root_floor(coord_gap(fx0, fx1) + coord_gap(fy0, fy1));
               r.gesture   = GEST_PINCH;
               r.value_one = VAL_BITS'(mag) - VAL_BITS'(prev_mag);
               prev_mag    = mag;
               if (pinch_fresh) begin
                  r.value_one = '0;
                  pinch_fresh = 1'b0;
                  drag_fresh  = 1'b1;
               end
            end else begin
               r.gesture   = GEST_DRAG;
               r.value_one = VAL_BITS'(fx0) - VAL_BITS'(prev_x);
               r.value_two = VAL_BITS'(fy0) - VAL_BITS'(prev_y);
               if (drag_fresh) begin
                  r.value_one = '0;
                  r.value_two = '0;
                  drag_fresh  = 1'b0;
                  pinch_fresh = 1'b1;
               end
            end
         end
         prev_x = fx0;
         prev_y = fy0;
      end else if (touch_held) begin
         held_for = now - hold_start;
         if (held_for < TIME_BITS'(tap_ms)) begin
            r.gesture   = GEST_PRESS;
            r.value_one = VAL_BITS'(prev_x);
            r.value_two = VAL_BITS'(prev_y);
         end
         release_touch();
      end
      return r;
   endfunction

   always @(posedge clock) begin
      gesture_result want;
      if (reset) begin
         hold_ms = HOLD_MS_RESET;
         tap_ms  = TAP_MS_RESET;
         release_touch();
         expected_gestures.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_HOLD_MS: hold_ms = csr_wdata;
               CSR_TAP_MS:  tap_ms  = csr_wdata;
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            expected_gestures.push_back(classify_frame(req_ch.touch_count, req_ch.x0, req_ch.y0,
                                                       req_ch.x1, req_ch.y1, req_ch.now_ms));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_gestures.size() == 0) begin
               $error("result transfer with no frame outstanding: gesture %0d", rsp_ch.gesture);
               mismatches++;
            end else begin
               want = expected_gestures.pop_front();
               if (rsp_ch.gesture !== want.gesture) begin
                  $error("gesture: expected %0d, got %0d", want.gesture, rsp_ch.gesture);
                  mismatches++;
               end
               if (rsp_ch.value_one !== want.value_one) begin
                  $error("value_one: expected %0d, got %0d", want.value_one, rsp_ch.value_one);
                  mismatches++;
               end
               if (rsp_ch.value_two !== want.value_two) begin
                  $error("value_two: expected %0d, got %0d", want.value_two, rsp_ch.value_two);
                  mismatches++;
               end
            end
         end
      end
      awaited = expected_gestures.size();
   end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
   import tgc_pkg::*;

   localparam int COORD_BITS      = 12;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int PHASE_FRAMES    = 280;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int SETTLE_CYCLES   = 30;

   logic                     clock;
   logic                     reset;
   logic                     csr_wr_en;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;
   int                       mismatches;
   int                       awaited;
   int                       send_idle_pct = 38;
   int                       recv_idle_pct = 84;
   int                       hold_off_requests = 0;
   int                       cycle_count = 0;
   int                       frames_sent = 0;
   logic [TIME_BITS-1:0]     frame_ms;
   logic [COORD_BITS-1:0]    pos_x;
   logic [COORD_BITS-1:0]    pos_y;

   tgc_req_if #(.COORD_BITS(COORD_BITS)) req_ch ();
   tgc_rsp_if rsp_ch ();

   touch_gesture_classifier #(
      .COORD_BITS(COORD_BITS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tgc_gesture_checker #(
      .COORD_BITS(COORD_BITS)
   ) i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .awaited    (awaited)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold-off whenever one is requested
   initial begin
      int served;
      served = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (served != hold_off_requests) begin
            served = hold_off_requests;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_frame(input logic [COUNT_BITS-1:0] count,
                             input logic [COORD_BITS-1:0] fx0, input logic [COORD_BITS-1:0] fy0,
                             input logic [COORD_BITS-1:0] fx1, input logic [COORD_BITS-1:0] fy1,
                             input logic [TIME_BITS-1:0]  now);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.touch_count <= count;
      req_ch.x0          <= fx0;
      req_ch.y0          <= fy0;
      req_ch.x1          <= fx1;
      req_ch.y1          <= fy1;
      req_ch.now_ms      <= now;
      do @(posedge clock); while (!req_ch.ready);
      frames_sent++;
      @(negedge clock);
   endtask

   task automatic wait_all_results();
      while (awaited != 0) @(negedge clock);
   endtask

   // leaves the write enable high; the caller drops it after the last write
   task automatic write_register(input logic [CSR_IDX_BITS-1:0] index,
                                 input logic [CSR_DATA_BITS-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   task automatic set_thresholds(input logic [CSR_DATA_BITS-1:0] hold,
                                 input logic [CSR_DATA_BITS-1:0] tap);
      req_ch.valid <= 1'b0;
      wait_all_results();
      write_register(CSR_HOLD_MS, hold);
      write_register(CSR_TAP_MS, tap);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [COORD_BITS-1:0] nudge(input logic [COORD_BITS-1:0] p);
      int v;
      v = int'(p) + int'($urandom_range(0, 64)) - 32;
      if (v < 0) v = 0;
      if (v > (1 << COORD_BITS) - 1) v = (1 << COORD_BITS) - 1;
      return COORD_BITS'(v);
   endfunction

   // touch down, move or pinch for a while, then lift
   task automatic touch_session(input int frames, input int step_max);
      logic [COUNT_BITS-1:0] count;
      count = ($urandom_range(0, 1) != 0) ? COUNT_BITS'(1) : COUNT_BITS'(2);
      if ($urandom_range(0, 19) == 0) frame_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      for (int i = 0; i < frames; i++) begin
         frame_ms += $urandom_range(0, step_max);
         if ($urandom_range(0, 3) == 0) begin
            count = ($urandom_range(0, 1) != 0) ? COUNT_BITS'(1)
                                                : COUNT_BITS'($urandom_range(2, 15));
         end
         if ($urandom_range(0, 1) != 0) begin
            pos_x = nudge(pos_x);
            pos_y = nudge(pos_y);
         end else begin
            pos_x = COORD_BITS'($urandom);
            pos_y = COORD_BITS'($urandom);
         end
         send_frame(count, pos_x, pos_y, COORD_BITS'($urandom), COORD_BITS'($urandom), frame_ms);
      end
      frame_ms += $urandom_range(0, step_max);
      send_frame('0, COORD_BITS'($urandom), COORD_BITS'($urandom), COORD_BITS'($urandom),
                 COORD_BITS'($urandom), frame_ms);
   endtask

   task automatic run_phase(input logic [CSR_DATA_BITS-1:0] hold,
                            input logic [CSR_DATA_BITS-1:0] tap,
                            input int send_pct, input int recv_pct,
                            input bit hold_off, input bit pause_midway);
      int stop_at;
      int steps[6];
      steps = '{1, 8, 60, 300, 2000, 25000};
      set_thresholds(hold, tap);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      if (hold_off) hold_off_requests++;
      stop_at = frames_sent + PHASE_FRAMES;
      while (frames_sent < stop_at) begin
         if (pause_midway && frames_sent >= stop_at - PHASE_FRAMES / 2) begin
            pause_midway = 1'b0;
            req_ch.valid <= 1'b0;
            wait_all_results();
         end
         if ($urandom_range(0, 6) == 0) begin
            // stray frame: any count, any time
            send_frame(COUNT_BITS'($urandom), COORD_BITS'($urandom), COORD_BITS'($urandom),
                       COORD_BITS'($urandom), COORD_BITS'($urandom),
                       ($urandom_range(0, 1) != 0) ? TIME_BITS'($urandom)
                                                   : frame_ms + $urandom_range(0, 500));
         end else begin
            touch_session($urandom_range(1, 12), steps[$urandom_range(0, 5)]);
         end
      end
   endtask

   initial begin
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_index          = CSR_HOLD_MS;
      csr_wdata          = '0;
      req_ch.valid       = 1'b0;
      req_ch.touch_count = '0;
      req_ch.x0          = '0;
      req_ch.y0          = '0;
      req_ch.x1          = '0;
      req_ch.y1          = '0;
      req_ch.now_ms      = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset thresholds: hold 250, tap 500
      send_frame('0, '1, '1, '1, '1, 32'd0);              // lift with nothing held
      send_frame(4'd1, '1, '0, '0, '1, 32'd100);          // touch starts the hold
      send_frame('0, '0, '0, '0, '0, 32'd200);            // quick lift gives a press
      send_frame(4'd15, '0, '1, '1, '0, 32'd1000);
      send_frame(4'd15, '0, '1, '1, '0, 32'd1250);        // first pinch, widest span
      send_frame(4'd2, '0, '0, '0, '0, 32'd1260);         // pinch collapses to zero
      send_frame(4'd2, '1, '1, '0, '0, 32'd1270);
      send_frame(4'd1, '1, '1, '0, '0, 32'd1280);         // first drag
      send_frame(4'd1, '0, '0, '1, '1, 32'd1290);         // largest negative step
      send_frame(4'd1, '1, '1, '0, '0, 32'd1295);         // largest positive step
      send_frame(4'd3, '1, '1, '1, '1, 32'd1298);         // pinch again after drag
      send_frame('0, '0, '0, '0, '0, 32'd1300);           // lift within tap time
      send_frame(4'd1, 12'd123, 12'd456, 12'd789, 12'd1011, 32'd2000);
      send_frame('0, '0, '0, '0, '0, 32'd2500);           // lift exactly at tap time
      send_frame(4'd1, 12'd2730, 12'd1365, '0, '0, 32'hFFFF_FF80);
      send_frame(4'd1, 12'd2731, 12'd1364, '0, '0, 32'h0000_0080); // elapsed wraps
      send_frame('0, '0, '0, '0, '0, 32'h0000_0100);
      set_thresholds('0, '0);
      send_frame(4'd1, 12'd77, 12'd88, '0, '0, 32'd5000);  // zero hold drags at once
      send_frame(4'd2, 12'd77, 12'd88, 12'd99, 12'd11, 32'd5000);
      send_frame('0, '0, '0, '0, '0, 32'd5000);           // zero tap never presses

      frame_ms = $urandom;
      pos_x    = COORD_BITS'($urandom);
      pos_y    = COORD_BITS'($urandom);
      run_phase(16'd250, 16'd500, 38, 84, 1'b0, 1'b0);
      run_phase(16'd0, 16'hFFFF, 38, 84, 1'b1, 1'b0);
      run_phase(16'hFFFF, 16'd0, 84, 38, 1'b0, 1'b0);
      run_phase(CSR_DATA_BITS'($urandom), CSR_DATA_BITS'($urandom), 84, 38, 1'b0, 1'b1);
      run_phase(16'd40, 16'd120, 0, 0, 1'b0, 1'b0);
      run_phase(CSR_DATA_BITS'($urandom_range(0, 2000)), CSR_DATA_BITS'($urandom_range(0, 4000)),
                0, 0, 1'b0, 1'b0);

      req_ch.valid <= 1'b0;
      wait_all_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && awaited == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
